// ===== src/csq_pkg.sv =====
// Shared types and codes for the counting semaphore with wait queue.
// Used by csq_alu, csq_ctrl and counting_semaphore_wait_queue; no dependencies.
`default_nettype none

package csq_pkg;

   localparam int TICK_W   = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int ID_OUT_W = 8;
   localparam int WOKEN_W  = 5;
   localparam int IN_ID_W  = 8;
   localparam int IN_CNT_W = 16;

   localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SIGNAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_ACQUIRED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_WOKEN     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMED_OUT = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd5;

   typedef enum logic [1:0] {
      ALU_DEC,
      ALU_SUB,
      ALU_ADD_SAT
   } alu_op_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [ID_OUT_W-1:0] waiter_id;
      logic [WOKEN_W-1:0]  woken_count;
      logic                last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/csq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module csq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/csq_alu.sv =====
// Shared arithmetic unit: decrement, subtract and saturating add.
// Depends on csq_pkg for the operation codes.
`default_nettype none

module csq_alu #(
   parameter int AW = 16,
   parameter int CW = 16
) (
   input  wire csq_pkg::alu_op_type op,
   input  wire logic [AW-1:0]       a_in,
   input  wire logic [AW-1:0]       b_in,
   output logic      [AW-1:0]       result
);

   localparam logic [AW:0] SAT_MAX = (AW+1)'({CW{1'b1}});

   logic [AW:0] sum;

   always_comb begin
      sum = {1'b0, a_in} + {1'b0, b_in};
      case (op)
         csq_pkg::ALU_DEC:     result = a_in - AW'(1);
         csq_pkg::ALU_SUB:     result = a_in - b_in;
         csq_pkg::ALU_ADD_SAT: result = (sum > SAT_MAX) ? SAT_MAX[AW-1:0] : sum[AW-1:0];
         default:              result = a_in;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/csq_ctrl.sv =====
// Sequencer for the semaphore: count, circular wait queue in RAM, queue walks.
// Depends on csq_pkg, csq_alu and csq_ram.
`default_nettype none

module csq_ctrl #(
   parameter int QUEUE_DEPTH     = 16,
   parameter int WAITER_ID_WIDTH = 8,
   parameter int COUNT_WIDTH     = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [csq_pkg::KIND_W-1:0]           req_kind,
   input  wire logic [csq_pkg::IN_ID_W-1:0]          req_waiter_id,
   input  wire logic [csq_pkg::TICK_W-1:0]           req_timeout_ticks,
   input  wire logic [csq_pkg::IN_CNT_W-1:0]         req_signal_count,
   input  wire logic                                 csr_write_en,
   input  wire logic [csq_pkg::IN_CNT_W-1:0]         csr_start_count,
   input  wire logic                                 out_free,
   output csq_pkg::rsp_item_type                     emit
);

   localparam int PW  = $clog2(QUEUE_DEPTH);
   localparam int LW  = $clog2(QUEUE_DEPTH + 1);
   localparam int TW  = csq_pkg::TICK_W;
   localparam int EW  = WAITER_ID_WIDTH + TW;
   localparam int AW1 = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;
   localparam int AW  = (AW1 > LW) ? AW1 : LW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAIT,
      S_SIG_START,
      S_SIG_POP,
      S_SIG_SUB,
      S_SIG_ADD,
      S_TICK_START,
      S_TICK_EVAL,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [WAITER_ID_WIDTH-1:0] id_ff;
   logic [TW-1:0]              tmo_ff;
   logic [COUNT_WIDTH-1:0]     sig_ff;
   logic [COUNT_WIDTH-1:0]     avail_ff;
   logic [COUNT_WIDTH-1:0]     rem_ff;
   logic [PW-1:0]              head_ff;
   logic [PW-1:0]              tail_ff;
   logic [PW-1:0]              rd_ptr_ff;
   logic [PW-1:0]              wr_ptr_ff;
   logic [LW-1:0]              len_ff;
   logic [LW-1:0]              woken_ff;
   logic [LW-1:0]              vis_ff;
   logic [LW-1:0]              kept_ff;

   logic                       ram_rd_en;
   logic [PW-1:0]              ram_rd_addr;
   logic                       ram_wr_en;
   logic [PW-1:0]              ram_wr_addr;
   logic [EW-1:0]              ram_wr_data;
   logic [EW-1:0]              ram_rd_data;

   csq_pkg::alu_op_type        alu_op;
   logic [AW-1:0]              alu_a;
   logic [AW-1:0]              alu_b;
   logic [AW-1:0]              alu_res;

   logic [WAITER_ID_WIDTH-1:0] ent_id;
   logic [TW-1:0]              ent_ticks;
   logic [TW-1:0]              new_ticks;
   logic                       tick_expired;
   logic                       tick_adv;
   logic                       tick_more;
   logic [LW-1:0]              vis_plus;
   logic [LW-1:0]              kept_in;
   logic [PW-1:0]              wr_ptr_in;
   logic [LW-1:0]              woken_plus;
   logic                       sig_adv;
   logic                       sig_more;
   logic                       queue_full;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   csq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   csq_alu #(
      .AW (AW),
      .CW (COUNT_WIDTH)
   ) u_alu (
      .op     (alu_op),
      .a_in   (alu_a),
      .b_in   (alu_b),
      .result (alu_res)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ent_id       = ram_rd_data[EW-1:TW];
      ent_ticks    = ram_rd_data[TW-1:0];
      queue_full   = (len_ff == LW'(QUEUE_DEPTH));

      alu_op = csq_pkg::ALU_DEC;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         S_WAIT: begin
            alu_a = AW'(avail_ff);
         end
         S_TICK_EVAL: begin
            alu_a = AW'(ent_ticks);
         end
         S_SIG_SUB: begin
            alu_op = csq_pkg::ALU_SUB;
            alu_a  = AW'(sig_ff);
            alu_b  = AW'(woken_ff);
         end
         S_SIG_ADD: begin
            alu_op = csq_pkg::ALU_ADD_SAT;
            alu_a  = AW'(avail_ff);
            alu_b  = AW'(rem_ff);
         end
         default: begin
            alu_op = csq_pkg::ALU_DEC;
         end
      endcase

      tick_expired = (ent_ticks != '0) && (alu_res[TW-1:0] == '0);
      new_ticks    = (ent_ticks == '0) ? '0 : alu_res[TW-1:0];
      tick_adv     = (state_ff == S_TICK_EVAL) && (!tick_expired || out_free);
      vis_plus     = vis_ff + LW'(1);
      tick_more    = (vis_plus != len_ff);
      kept_in      = tick_expired ? kept_ff : kept_ff + LW'(1);
      wr_ptr_in    = tick_expired ? wr_ptr_ff : ptr_inc(wr_ptr_ff);

      woken_plus   = woken_ff + LW'(1);
      sig_adv      = (state_ff == S_SIG_POP) && out_free;
      sig_more     = (AW'(woken_plus) != AW'(sig_ff)) && (len_ff != LW'(1));

      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = {id_ff, tmo_ff};
      emit        = '0;

      case (state_ff)
         S_WAIT: begin
            if (out_free) begin
               emit.valid     = 1'b1;
               emit.last      = 1'b1;
               emit.waiter_id = csq_pkg::ID_OUT_W'(id_ff);
               if (avail_ff != '0) begin
                  emit.status = csq_pkg::STATUS_ACQUIRED;
               end else if (!queue_full) begin
                  emit.status = csq_pkg::STATUS_QUEUED;
                  ram_wr_en   = 1'b1;
               end else begin
                  emit.status = csq_pkg::STATUS_FULL;
               end
            end
         end
         S_SIG_START: begin
            ram_rd_en = (sig_ff != '0) && (len_ff != '0);
         end
         S_SIG_POP: begin
            if (sig_adv) begin
               emit.valid     = 1'b1;
               emit.status    = csq_pkg::STATUS_WOKEN;
               emit.waiter_id = csq_pkg::ID_OUT_W'(ent_id);
               ram_rd_en      = sig_more;
               ram_rd_addr    = ptr_inc(head_ff);
            end
         end
         S_TICK_START: begin
            ram_rd_en = (len_ff != '0);
         end
         S_TICK_EVAL: begin
            if (tick_adv) begin
               if (tick_expired) begin
                  emit.valid     = 1'b1;
                  emit.status    = csq_pkg::STATUS_TIMED_OUT;
                  emit.waiter_id = csq_pkg::ID_OUT_W'(ent_id);
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wr_ptr_ff;
                  ram_wr_data = {ent_id, new_ticks};
               end
               ram_rd_en   = tick_more;
               ram_rd_addr = rd_ptr_ff;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit.valid       = 1'b1;
               emit.status      = csq_pkg::STATUS_DONE;
               emit.woken_count = csq_pkg::WOKEN_W'(woken_ff);
               emit.last        = 1'b1;
            end
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         avail_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         len_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            avail_ff <= COUNT_WIDTH'(csr_start_count);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  id_ff    <= WAITER_ID_WIDTH'(req_waiter_id);
                  tmo_ff   <= req_timeout_ticks;
                  sig_ff   <= COUNT_WIDTH'(req_signal_count);
                  woken_ff <= '0;
                  case (req_kind)
                     csq_pkg::KIND_WAIT:   state_ff <= S_WAIT;
                     csq_pkg::KIND_SIGNAL: state_ff <= S_SIG_START;
                     csq_pkg::KIND_TICK:   state_ff <= S_TICK_START;
                     default:              state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WAIT: begin
               if (out_free) begin
                  if (avail_ff != '0) begin
                     avail_ff <= COUNT_WIDTH'(alu_res);
                  end else if (!queue_full) begin
                     tail_ff <= ptr_inc(tail_ff);
                     len_ff  <= len_ff + LW'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_SIG_START: begin
               if ((sig_ff != '0) && (len_ff != '0)) begin
                  state_ff <= S_SIG_POP;
               end else begin
                  state_ff <= S_SIG_SUB;
               end
            end
            S_SIG_POP: begin
               if (sig_adv) begin
                  head_ff  <= ptr_inc(head_ff);
                  len_ff   <= len_ff - LW'(1);
                  woken_ff <= woken_plus;
                  state_ff <= sig_more ? S_SIG_POP : S_SIG_SUB;
               end
            end
            S_SIG_SUB: begin
               rem_ff   <= COUNT_WIDTH'(alu_res);
               state_ff <= S_SIG_ADD;
            end
            S_SIG_ADD: begin
               avail_ff <= COUNT_WIDTH'(alu_res);
               state_ff <= S_DONE;
            end
            S_TICK_START: begin
               rd_ptr_ff <= ptr_inc(head_ff);
               wr_ptr_ff <= head_ff;
               vis_ff    <= '0;
               kept_ff   <= '0;
               state_ff  <= (len_ff != '0) ? S_TICK_EVAL : S_DONE;
            end
            S_TICK_EVAL: begin
               if (tick_adv) begin
                  vis_ff    <= vis_plus;
                  kept_ff   <= kept_in;
                  wr_ptr_ff <= wr_ptr_in;
                  if (tick_more) begin
                     rd_ptr_ff <= ptr_inc(rd_ptr_ff);
                  end else begin
                     len_ff   <= kept_in;
                     tail_ff  <= wr_ptr_in;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a first-in first-out wait queue of waiter ids.
// Depends on csq_pkg and csq_ctrl (which holds csq_alu and csq_ram).
//
// Usage: items arrive on the req_ channel (valid/ready). A wait item either
// takes one unit, queues its waiter with a timeout, or is refused when the
// queue is full. A signal item wakes queued waiters oldest first and adds the
// units left over to the count, saturating. A tick item counts down finite
// timeouts and removes waiters that expire. Each result item leaves on the
// rsp_ channel; rsp_last marks the final result of an input item.
// The queue walk reads one RAM entry per cycle except while held by a stalled
// receiver, and the count update goes through the single shared adder.
// req_ready is high only between items. A result register sits at the output,
// so the next item is accepted while the last result of the previous one
// waits. When the receiver stalls, the walk holds at the entry whose result
// cannot yet be delivered. Reset empties the queue and clears the count; a
// csr_ write loads the count.
`default_nettype none

module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH     = 16,
   parameter int WAITER_ID_WIDTH = 8,
   parameter int COUNT_WIDTH     = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [csq_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [csq_pkg::IN_ID_W-1:0]      req_waiter_id,
   input  wire logic [csq_pkg::TICK_W-1:0]       req_timeout_ticks,
   input  wire logic [csq_pkg::IN_CNT_W-1:0]     req_signal_count,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [csq_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [csq_pkg::ID_OUT_W-1:0]     rsp_waiter_id_res,
   output logic      [csq_pkg::WOKEN_W-1:0]      rsp_woken_count,
   output logic                                  rsp_last,
   input  wire logic                             csr_write_en,
   input  wire logic [csq_pkg::IN_CNT_W-1:0]     csr_start_count
);

   csq_pkg::rsp_item_type             emit;
   logic                              out_free;
   logic                              rsp_valid_ff;
   logic [csq_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [csq_pkg::ID_OUT_W-1:0]      rsp_id_ff;
   logic [csq_pkg::WOKEN_W-1:0]       rsp_woken_ff;
   logic                              rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   csq_ctrl #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .WAITER_ID_WIDTH (WAITER_ID_WIDTH),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_waiter_id     (req_waiter_id),
      .req_timeout_ticks (req_timeout_ticks),
      .req_signal_count  (req_signal_count),
      .csr_write_en      (csr_write_en),
      .csr_start_count   (csr_start_count),
      .out_free          (out_free),
      .emit              (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid) begin
         rsp_status_ff <= emit.status;
         rsp_id_ff     <= emit.waiter_id;
         rsp_woken_ff  <= emit.woken_count;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_waiter_id_res = rsp_id_ff;
   assign rsp_woken_count   = rsp_woken_ff;
   assign rsp_last          = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("A result was produced while the output register was occupied.");

   a_busy_mid_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("A new item was offered while an item still had results pending.");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csq_pkg::STATUS_DONE)) |-> rsp_last)
      else $error("A done result was not marked as the final result.");

   a_woken_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_woken_count != '0)) |-> (rsp_status == csq_pkg::STATUS_DONE))
      else $error("A woken count appeared on a result other than done.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind != csq_pkg::KIND_IGNORED)) |=> !req_ready)
      else $error("The block was ready again right after taking an item.");

endmodule

`default_nettype wire
